// ----- design/ttyld_pkg.sv -----
`default_nettype none

package ttyld_pkg;

   localparam int RING_DEPTH = 64;
   localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FILL_W     = $clog2(RING_DEPTH + 1);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_NL    = 8'h0A;

   typedef enum logic [1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_OPEN  = 2'd1,
      FUNC_DRAIN = 2'd2,
      FUNC_SPARE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      KIND_STORE     = 3'd0,
      KIND_BACKSPACE = 3'd1,
      KIND_NEWLINE   = 3'd2,
      KIND_DONE      = 3'd3,
      KIND_ACCEPT    = 3'd4
   } kind_type;

   // one classified request: an optional leading response, then an optional
   // newline echo plus completion pair
   typedef struct packed {
      logic        has_first;
      kind_type    first_kind;
      logic [7:0]  first_char;
      logic [15:0] first_count;
      logic [7:0]  first_tag;
      logic        has_tail;
      logic [15:0] tail_count;
      logic [7:0]  tail_tag;
   } job_type;

endpackage

`default_nettype wire

// ----- design/ttyld_front.sv -----
`default_nettype none

module ttyld_front
   import ttyld_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_key_char,
   input  wire logic [15:0] req_request_count,
   input  wire logic [7:0]  req_requester,
   output logic             job_valid,
   output job_type          job,
   input  wire logic        job_ready
);

   logic [7:0]        ring_mem [RING_DEPTH];
   logic [RING_AW-1:0] head_ff, tail_ff;
   logic [FILL_W-1:0]  fill_ff;

   logic        s1_valid_ff;
   logic        s1_open_ff;
   logic [15:0] s1_count_ff;
   logic [7:0]  s1_tag_ff;
   logic [7:0]  s1_char_ff;

   logic [15:0] left_ff, left_in;
   logic [15:0] done_ff, done_in;
   logic [7:0]  pend_ff, pend_in;

   logic accept, do_push, do_pop, do_open, s1_advance, job_any;

   assign accept  = req_valid && req_ready;
   assign do_push = accept && (req_func == FUNC_PUSH) &&
                    (fill_ff != FILL_W'(RING_DEPTH));
   assign do_pop  = accept && (req_func == FUNC_DRAIN) && (fill_ff != '0);
   assign do_open = accept && (req_func == FUNC_OPEN);

   assign job_any    = job.has_first || job.has_tail;
   assign s1_advance = s1_valid_ff && (!job_any || job_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign job_valid  = s1_valid_ff && job_any;

   // ring pointers and store
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (do_push) begin
            head_ff <= (head_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            fill_ff <= fill_ff + 1'b1;
         end
         if (do_pop) begin
            tail_ff <= (tail_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ring_mem[head_ff] <= req_key_char;
      end
   end

   // classify stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= do_open || do_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_open_ff  <= do_open;
         s1_count_ff <= req_request_count;
         s1_tag_ff   <= req_requester;
      end
      if (do_pop) begin
         s1_char_ff <= ring_mem[tail_ff];
      end
   end

   always_comb begin
      left_in = left_ff;
      done_in = done_ff;
      pend_in = pend_ff;
      job.has_first   = 1'b0;
      job.first_kind  = KIND_STORE;
      job.first_char  = 8'h00;
      job.first_count = 16'h0000;
      job.first_tag   = 8'h00;
      job.has_tail    = 1'b0;
      job.tail_count  = 16'h0000;
      job.tail_tag    = 8'h00;
      if (s1_open_ff) begin
         left_in = s1_count_ff;
         done_in = 16'h0000;
         pend_in = s1_tag_ff;
         job.has_first   = 1'b1;
         job.first_kind  = KIND_ACCEPT;
         job.first_count = s1_count_ff;
         job.first_tag   = s1_tag_ff;
      end else if (left_ff != 16'h0000) begin
         if (s1_char_ff >= CH_SPACE && s1_char_ff <= CH_TILDE) begin
            done_in = done_ff + 16'd1;
            left_in = left_ff - 16'd1;
            job.has_first   = 1'b1;
            job.first_kind  = KIND_STORE;
            job.first_char  = s1_char_ff;
            job.first_count = done_ff;
         end else if (s1_char_ff == CH_BS && done_ff != 16'h0000) begin
            done_in = done_ff - 16'd1;
            left_in = left_ff + 16'd1;
            job.has_first   = 1'b1;
            job.first_kind  = KIND_BACKSPACE;
            job.first_char  = CH_BS;
            job.first_count = done_ff - 16'd1;
         end
         if (s1_char_ff == CH_NL || left_in == 16'h0000) begin
            job.has_tail   = 1'b1;
            job.tail_count = done_in;
            job.tail_tag   = pend_ff;
            left_in        = 16'h0000;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         done_ff <= '0;
         pend_ff <= '0;
      end else if (s1_advance) begin
         left_ff <= left_in;
         done_ff <= done_in;
         pend_ff <= pend_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/ttyld_queue.sv -----
`default_nettype none

module ttyld_queue
   import ttyld_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire job_type in_job,
   output logic         out_valid,
   input  wire logic    out_ready,
   output job_type      out_job
);

   job_type    slot_mem [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_job   = slot_mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop)      count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_mem[wr_ptr_ff] <= in_job;
      end
   end

endmodule

`default_nettype wire

// ----- design/ttyld_back.sv -----
`default_nettype none

module ttyld_back
   import ttyld_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   output logic         job_pop,
   input  wire job_type job,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic [2:0]   rsp_kind,
   output logic [7:0]   rsp_out_char,
   output logic [15:0]  rsp_count,
   output logic [7:0]   rsp_out_requester,
   output logic         rsp_last
);

   typedef enum logic [1:0] {
      STEP_FIRST   = 2'd0,
      STEP_NEWLINE = 2'd1,
      STEP_DONE    = 2'd2
   } step_type;

   step_type    step_ff, cur_step, next_step;
   logic        rsp_valid_ff;
   kind_type    kind_ff, cur_kind;
   logic [7:0]  char_ff, cur_char;
   logic [15:0] count_ff, cur_count;
   logic [7:0]  tag_ff, cur_tag;
   logic        last_ff, cur_last;
   logic        load;

   assign load    = job_valid && (!rsp_valid_ff || rsp_ready);
   assign job_pop = load && cur_last;

   always_comb begin
      cur_step = step_ff;
      if (step_ff == STEP_FIRST && !job.has_first) cur_step = STEP_NEWLINE;
      unique case (cur_step)
         STEP_FIRST: begin
            cur_kind  = job.first_kind;
            cur_char  = job.first_char;
            cur_count = job.first_count;
            cur_tag   = job.first_tag;
            cur_last  = !job.has_tail;
            next_step = STEP_NEWLINE;
         end
         STEP_NEWLINE: begin
            cur_kind  = KIND_NEWLINE;
            cur_char  = CH_NL;
            cur_count = job.tail_count;
            cur_tag   = 8'h00;
            cur_last  = 1'b0;
            next_step = STEP_DONE;
         end
         default: begin
            cur_kind  = KIND_DONE;
            cur_char  = 8'h00;
            cur_count = job.tail_count;
            cur_tag   = job.tail_tag;
            cur_last  = 1'b1;
            next_step = STEP_FIRST;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= STEP_FIRST;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            step_ff      <= cur_last ? STEP_FIRST : next_step;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         kind_ff  <= cur_kind;
         char_ff  <= cur_char;
         count_ff <= cur_count;
         tag_ff   <= cur_tag;
         last_ff  <= cur_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_out_char      = char_ff;
   assign rsp_count         = count_ff;
   assign rsp_out_requester = tag_ff;
   assign rsp_last          = last_ff;

endmodule

`default_nettype wire

// ----- design/tty_line_input_discipline_core.sv -----
// Terminal input line discipline.
// Request channel (req_*): func 0 pushes req_key_char into a 64-byte ring
// (dropped when full), func 1 opens a read of req_request_count bytes for
// req_requester, func 2 drains one buffered byte. Code 3 is ignored.
// Response channel (rsp_*): echoes, read accepted and read complete records;
// rsp_last marks the final response of one request.
// A request's first response passes the classify register, then the job
// queue, then the output register. One request per cycle while req_ready is
// high; a request with n responses gives them in turn from the single output
// register draining the queue.
// Pushes and drains with no response retire in the front without queue space.
// Reset clears ring pointers, fill, open-read state, queue and output valid;
// ring contents are not cleared.
// When the receiver stalls, the output register holds, then the two-entry job
// queue fills, then the classify stage holds and req_ready drops.
`default_nettype none

module tty_line_input_discipline_core
   import ttyld_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_key_char,
   input  wire logic [15:0] req_request_count,
   input  wire logic [7:0]  req_requester,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_out_char,
   output logic [15:0]      rsp_count,
   output logic [7:0]       rsp_out_requester,
   output logic             rsp_last
);

   logic    fq_valid, fq_ready, qb_valid, qb_pop;
   job_type fq_job, qb_job;

   ttyld_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_key_char      (req_key_char),
      .req_request_count (req_request_count),
      .req_requester     (req_requester),
      .job_valid         (fq_valid),
      .job               (fq_job),
      .job_ready         (fq_ready)
   );

   ttyld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_job    (fq_job),
      .out_valid (qb_valid),
      .out_ready (qb_pop),
      .out_job   (qb_job)
   );

   ttyld_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (qb_valid),
      .job_pop           (qb_pop),
      .job               (qb_job),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_out_char      (rsp_out_char),
      .rsp_count         (rsp_count),
      .rsp_out_requester (rsp_out_requester),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

// ----- design/ttyld_checker.sv -----
`default_nettype none

module ttyld_checker
   import ttyld_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_kind,
   input wire logic [7:0]  rsp_out_char,
   input wire logic [15:0] rsp_count,
   input wire logic [7:0]  rsp_out_requester,
   input wire logic        rsp_last
);

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_count) && $stable(rsp_out_char) && $stable(rsp_out_requester) &&
      $stable(rsp_last))
      else $error("stalled response changed");

   a_accept_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ACCEPT |-> rsp_last)
      else $error("read accepted not a lone response");

   a_newline_then_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == KIND_NEWLINE |=>
      rsp_valid && rsp_kind == KIND_DONE && rsp_last && $stable(rsp_count))
      else $error("newline echo not followed by completion");

   a_newline_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_NEWLINE |-> rsp_out_char == CH_NL && !rsp_last)
      else $error("newline echo malformed");

endmodule

bind tty_line_input_discipline_core ttyld_checker u_checker (.*);

`default_nettype wire

// ----- dv/tb_tty_line_input_discipline_core.sv -----
`timescale 1ns / 100ps

module tb_tty_line_input_discipline_core;
   import ttyld_pkg::*;

   localparam int LIMIT      = 200000;
   localparam int N_ITEMS    = 425;
   localparam int QUIET_FROM = 100;
   localparam int QUIET_TO   = 250;
   localparam int HOLD_AT    = 300;
   localparam int HOLD_LEN   = 200;

   typedef struct {
      logic [1:0]  func;
      logic [7:0]  key;
      logic [15:0] want;
      logic [7:0]  tag;
   } tty_req_type;

   typedef struct {
      kind_type    kind;
      logic [7:0]  ch;
      logic [15:0] count;
      logic [7:0]  tag;
      logic        is_last;
   } tty_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = FUNC_PUSH;
   logic [7:0]  req_key_char = 8'h00;
   logic [15:0] req_request_count = 16'h0000;
   logic [7:0]  req_requester = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_out_char;
   logic [15:0] rsp_count;
   logic [7:0]  rsp_out_requester;
   logic        rsp_last;

   tty_req_type tty_requests[$];
   tty_rsp_type line_responses_due[$];
   tty_req_type next_req;
   tty_rsp_type due;

   // predictor state
   logic [7:0]            ring_bytes[RING_DEPTH];
   logic [RING_AW-1:0]    ring_head = '0;
   logic [RING_AW-1:0]    ring_tail = '0;
   logic [FILL_W-1:0]     ring_fill = '0;
   logic [15:0]           bytes_left = '0;
   logic [15:0]           bytes_done = '0;
   logic [7:0]            open_tag = '0;

   int cycles = 0;
   int hold_left = 0;
   int queued = 0;
   int accepted = 0;
   int checked = 0;
   int reads_done = 0;
   int dropped = 0;
   int failures = 0;

   wire quiet = (cycles >= QUIET_FROM) && (cycles < QUIET_TO);

   tty_line_input_discipline_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_key_char      (req_key_char),
      .req_request_count (req_request_count),
      .req_requester     (req_requester),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_out_char      (rsp_out_char),
      .rsp_count         (rsp_count),
      .rsp_out_requester (rsp_out_requester),
      .rsp_last          (rsp_last)
   );

   always #5 clock = ~clock;

   task automatic add(input logic [1:0] func, input logic [7:0] key,
                      input logic [15:0] want, input logic [7:0] tag);
      tty_req_type r;
      r = '{func: func, key: key, want: want, tag: tag};
      tty_requests.push_back(r);
      queued++;
   endtask

   function automatic logic [7:0] printable();
      return 8'($urandom_range(CH_SPACE, CH_TILDE));
   endfunction

   task automatic flag_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endtask

   // line discipline update for one accepted request
   task automatic discipline_step(input logic [1:0] func, input logic [7:0] key,
                                  input logic [15:0] want, input logic [7:0] tag);
      tty_rsp_type r[3];
      int          n;
      logic [7:0]  ch;
      n = 0;
      case (func)
         FUNC_PUSH: begin
            if (ring_fill < RING_DEPTH) begin
               ring_bytes[ring_head] = key;
               ring_head = ring_head + 1'b1;
               ring_fill = ring_fill + 1'b1;
            end else begin
               dropped++;
            end
         end
         FUNC_OPEN: begin
            open_tag = tag;
            bytes_left = want;
            bytes_done = '0;
            r[n] = '{kind: KIND_ACCEPT, ch: 8'h00, count: want, tag: tag, is_last: 1'b0};
            n++;
         end
         FUNC_DRAIN: begin
            if (ring_fill != 0) begin
               ch = ring_bytes[ring_tail];
               ring_tail = ring_tail + 1'b1;
               ring_fill = ring_fill - 1'b1;
               if (bytes_left != 0) begin
                  if (ch >= CH_SPACE && ch <= CH_TILDE) begin
                     r[n] = '{kind: KIND_STORE, ch: ch, count: bytes_done, tag: 8'h00,
                              is_last: 1'b0};
                     n++;
                     bytes_done = bytes_done + 1'b1;
                     bytes_left = bytes_left - 1'b1;
                  end else if (ch == CH_BS && bytes_done != 0) begin
                     bytes_done = bytes_done - 1'b1;
                     bytes_left = bytes_left + 1'b1;
                     r[n] = '{kind: KIND_BACKSPACE, ch: CH_BS, count: bytes_done,
                              tag: 8'h00, is_last: 1'b0};
                     n++;
                  end
                  if (ch == CH_NL || bytes_left == 0) begin
                     r[n] = '{kind: KIND_NEWLINE, ch: CH_NL, count: bytes_done,
                              tag: 8'h00, is_last: 1'b0};
                     n++;
                     r[n] = '{kind: KIND_DONE, ch: 8'h00, count: bytes_done,
                              tag: open_tag, is_last: 1'b0};
                     n++;
                     bytes_left = '0;
                     reads_done++;
                  end
               end
            end
         end
         default: ;
      endcase
      for (int i = 0; i < n; i++) begin
         r[i].is_last = (i == n - 1);
         line_responses_due.push_back(r[i]);
      end
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles,
                  line_responses_due.size());
         $display("FAIL");
         $finish;
      end
   end

   // long receiver hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (cycles == HOLD_AT) begin
         hold_left <= HOLD_LEN;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            discipline_step(req_func, req_key_char, req_request_count, req_requester);
            accepted++;
         end
         if (!req_valid || req_ready) begin
            if (tty_requests.size() != 0 && (quiet || $urandom_range(0, 99) >= 6)) begin
               next_req = tty_requests.pop_front();
               req_valid <= 1'b1;
               req_func <= next_req.func;
               req_key_char <= next_req.key;
               req_request_count <= next_req.want;
               req_requester <= next_req.tag;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (line_responses_due.size() == 0) begin
               flag_failure($sformatf(
                  "unexpected response kind %0d char %h count %0d tag %h last %b",
                  rsp_kind, rsp_out_char, rsp_count, rsp_out_requester, rsp_last));
            end else begin
               due = line_responses_due.pop_front();
               checked++;
               if (rsp_kind !== due.kind || rsp_out_char !== due.ch ||
                   rsp_count !== due.count || rsp_out_requester !== due.tag ||
                   rsp_last !== due.is_last) begin
                  flag_failure($sformatf(
                     {"mismatch: exp kind %0d char %h count %0d tag %h last %b,",
                      " got kind %0d char %h count %0d tag %h last %b"},
                     due.kind, due.ch, due.count, due.tag, due.is_last,
                     rsp_kind, rsp_out_char, rsp_count, rsp_out_requester,
                     rsp_last));
               end
            end
         end
         rsp_ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 6);
      end
   end

   initial begin : stimulus
      int         pick;
      int         n;
      int         owed;
      int         r;
      bit         overflowed;
      logic [7:0] key;
      overflowed = 1'b0;

      // empty ring, unused code, discard without a read open
      add(FUNC_DRAIN, 8'h00, 16'h0000, 8'h00);
      add(FUNC_SPARE, 8'hFF, 16'hFFFF, 8'hFF);
      add(FUNC_PUSH, "A", 16'h0000, 8'h00);
      add(FUNC_DRAIN, 8'h00, 16'h0000, 8'h00);
      // zero count, then maximum count
      add(FUNC_OPEN, 8'h00, 16'h0000, 8'hFF);
      add(FUNC_OPEN, 8'h00, 16'hFFFF, 8'h00);
      add(FUNC_PUSH, CH_BS, 16'h0000, 8'h00);
      add(FUNC_PUSH, CH_SPACE, 16'h0000, 8'h00);
      add(FUNC_PUSH, CH_TILDE, 16'h0000, 8'h00);
      add(FUNC_PUSH, CH_BS, 16'h0000, 8'h00);
      add(FUNC_PUSH, 8'h7F, 16'h0000, 8'h00);
      add(FUNC_PUSH, 8'hFF, 16'h0000, 8'h00);
      add(FUNC_PUSH, 8'h01, 16'h0000, 8'h00);
      add(FUNC_PUSH, CH_NL, 16'h0000, 8'h00);
      repeat (8) add(FUNC_DRAIN, 8'h00, 16'h0000, 8'h00);
      // filled request
      add(FUNC_OPEN, 8'h00, 16'h0001, 8'h5A);
      add(FUNC_PUSH, "x", 16'h0000, 8'h00);
      add(FUNC_DRAIN, 8'h00, 16'h0000, 8'h00);

      while (queued < N_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 4 || (!overflowed && queued > 200)) begin
            overflowed = 1'b1;
            repeat (RING_DEPTH + $urandom_range(1, 6))
               add(FUNC_PUSH, 8'($urandom), 16'h0000, 8'h00);
            add(FUNC_OPEN, 8'h00, 16'($urandom), 8'($urandom));
            repeat (RING_DEPTH + 2) add(FUNC_DRAIN, 8'h00, 16'h0000, 8'h00);
         end else if (pick < 70) begin
            add(FUNC_OPEN, 8'($urandom), 16'($urandom_range(1, 12)), 8'($urandom));
            n = $urandom_range(1, 10);
            owed = 0;
            for (int i = 0; i < n; i++) begin
               r = $urandom_range(0, 99);
               if (r < 70) key = printable();
               else if (r < 82) key = CH_BS;
               else if (r < 90) key = 8'($urandom);
               else key = CH_NL;
               add(FUNC_PUSH, key, 16'($urandom), 8'($urandom));
               owed++;
               if ($urandom_range(0, 2) == 0) begin
                  add(FUNC_DRAIN, 8'($urandom), 16'($urandom), 8'($urandom));
                  owed--;
               end
            end
            if ($urandom_range(0, 1) == 0) begin
               add(FUNC_PUSH, CH_NL, 16'h0000, 8'h00);
               owed++;
            end
            repeat (owed + $urandom_range(0, 1)) add(FUNC_DRAIN, 8'h00, 16'h0000, 8'h00);
         end else begin
            repeat ($urandom_range(1, 3))
               add(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), 8'($urandom));
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (tty_requests.size() != 0 || req_valid) @(negedge clock);
      while (line_responses_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("%0d requests accepted, %0d responses checked, %0d reads completed",
               accepted, checked, reads_done);
      $display("%0d key bytes dropped on a full ring, %0d failures", dropped, failures);
      if (failures == 0 && line_responses_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
